FILE: src/cau_pkg.sv
// Package: types, constants and the divider step for the complex arithmetic unit.
package cau_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int SUM_W      = 2 * DATA_WIDTH + 1;
  localparam int DEN_W      = 2 * DATA_WIDTH + 1;

  localparam logic [1:0] CMD_ADD = 2'd0;
  localparam logic [1:0] CMD_SUB = 2'd1;
  localparam logic [1:0] CMD_MUL = 2'd2;
  localparam logic [1:0] CMD_DIV = 2'd3;

  typedef struct packed {
    logic [1:0]                   cmd;
    logic signed [DATA_WIDTH-1:0] a_re;
    logic signed [DATA_WIDTH-1:0] a_im;
    logic signed [DATA_WIDTH-1:0] b_re;
    logic signed [DATA_WIDTH-1:0] b_im;
  } cau_in_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] res_re;
    logic signed [DATA_WIDTH-1:0] res_im;
    logic                         overflow;
    logic                         div_zero;
  } cau_out_t;

  typedef struct packed {
    logic                    valid;
    logic                    is_div;
    logic                    dz;
    logic                    neg_re;
    logic                    neg_im;
    logic signed [SUM_W-1:0] val_re;
    logic signed [SUM_W-1:0] val_im;
  } cau_side_t;

  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic             q;
  } cau_step_t;

  function automatic cau_step_t cau_step(input logic [DEN_W-1:0] rem, input logic nbit,
                                         input logic [DEN_W-1:0] den);
    logic [DEN_W:0] trial;
    cau_step_t      s;
    trial = {rem, nbit};
    if (trial >= {1'b0, den}) begin
      s.rem = DEN_W'(trial - {1'b0, den});
      s.q   = 1'b1;
    end else begin
      s.rem = trial[DEN_W-1:0];
      s.q   = 1'b0;
    end
    return s;
  endfunction

endpackage

FILE: src/cau_front.sv
// Front end: input register, products, sums and divider operand preparation.
module cau_front #(
  parameter int FRAC_BITS = cau_pkg::FRAC_BITS,
  parameter int NUM_W     = cau_pkg::SUM_W + cau_pkg::FRAC_BITS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  cau_pkg::cau_in_t            in_data,
  output cau_pkg::cau_side_t          side_o,
  output logic [cau_pkg::DEN_W-1:0]   den_o,
  output logic [NUM_W-1:0]            nq_re_o,
  output logic [NUM_W-1:0]            nq_im_o
);

  localparam int DW = cau_pkg::DATA_WIDTH;
  localparam int SW = cau_pkg::SUM_W;
  localparam int NW = cau_pkg::DEN_W;

  // stage A
  logic             a_v_r;
  cau_pkg::cau_in_t a_r;

  // stage B
  logic                  b_v_r;
  logic [1:0]            b_cmd_r;
  logic signed [2*DW-1:0] p_rr_r, p_ii_r, p_ri_r, p_ir_r, s_r_r, s_i_r;
  logic signed [DW:0]    as_re_r, as_im_r;

  // stage C
  logic                  c_v_r;
  logic [1:0]            c_cmd_r;
  logic signed [SW-1:0]  c_val_re_r, c_val_im_r, c_n_re_r, c_n_im_r;
  logic [NW-1:0]         c_den_r;

  logic signed [DW:0]    as_re, as_im;
  logic signed [SW-1:0]  m_re, m_im;
  logic [SW-1:0]         mag_re, mag_im;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= in_valid;
    end
    if (en) begin
      a_r <= in_data;
    end
  end

  always_comb begin
    if (a_r.cmd == cau_pkg::CMD_SUB) begin
      as_re = (DW+1)'(a_r.a_re) - (DW+1)'(a_r.b_re);
      as_im = (DW+1)'(a_r.a_im) - (DW+1)'(a_r.b_im);
    end else begin
      as_re = (DW+1)'(a_r.a_re) + (DW+1)'(a_r.b_re);
      as_im = (DW+1)'(a_r.a_im) + (DW+1)'(a_r.b_im);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (en) begin
      b_v_r <= a_v_r;
    end
    if (en) begin
      b_cmd_r <= a_r.cmd;
      p_rr_r  <= a_r.a_re * a_r.b_re;
      p_ii_r  <= a_r.a_im * a_r.b_im;
      p_ri_r  <= a_r.a_re * a_r.b_im;
      p_ir_r  <= a_r.a_im * a_r.b_re;
      s_r_r   <= a_r.b_re * a_r.b_re;
      s_i_r   <= a_r.b_im * a_r.b_im;
      as_re_r <= as_re;
      as_im_r <= as_im;
    end
  end

  always_comb begin
    m_re = SW'(p_rr_r) - SW'(p_ii_r);
    m_im = SW'(p_ri_r) + SW'(p_ir_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
    end else if (en) begin
      c_v_r <= b_v_r;
    end
    if (en) begin
      c_cmd_r <= b_cmd_r;
      if (b_cmd_r == cau_pkg::CMD_MUL) begin
        c_val_re_r <= m_re >>> FRAC_BITS;
        c_val_im_r <= m_im >>> FRAC_BITS;
      end else begin
        c_val_re_r <= SW'(as_re_r);
        c_val_im_r <= SW'(as_im_r);
      end
      c_n_re_r <= SW'(p_rr_r) + SW'(p_ii_r);
      c_n_im_r <= SW'(p_ir_r) - SW'(p_ri_r);
      c_den_r  <= NW'($unsigned(s_r_r)) + NW'($unsigned(s_i_r));
    end
  end

  always_comb begin
    mag_re = c_n_re_r[SW-1] ? SW'(-c_n_re_r) : SW'(c_n_re_r);
    mag_im = c_n_im_r[SW-1] ? SW'(-c_n_im_r) : SW'(c_n_im_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_o <= '0;
    end else if (en) begin
      side_o.valid  <= c_v_r;
      side_o.is_div <= (c_cmd_r == cau_pkg::CMD_DIV);
      side_o.dz     <= (c_den_r == '0);
      side_o.neg_re <= c_n_re_r[SW-1];
      side_o.neg_im <= c_n_im_r[SW-1];
      side_o.val_re <= c_val_re_r;
      side_o.val_im <= c_val_im_r;
    end
    if (en) begin
      den_o   <= c_den_r;
      nq_re_o <= NUM_W'(mag_re) << FRAC_BITS;
      nq_im_o <= NUM_W'(mag_im) << FRAC_BITS;
    end
  end

endmodule

FILE: src/cau_div_cell.sv
// Divider cell: one restoring quotient bit for both parts, registered.
module cau_div_cell #(
  parameter int NUM_W = cau_pkg::SUM_W + cau_pkg::FRAC_BITS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  cau_pkg::cau_side_t        side_i,
  input  logic [cau_pkg::DEN_W-1:0] den_i,
  input  logic [cau_pkg::DEN_W-1:0] rem_re_i,
  input  logic [cau_pkg::DEN_W-1:0] rem_im_i,
  input  logic [NUM_W-1:0]          nq_re_i,
  input  logic [NUM_W-1:0]          nq_im_i,
  output cau_pkg::cau_side_t        side_o,
  output logic [cau_pkg::DEN_W-1:0] den_o,
  output logic [cau_pkg::DEN_W-1:0] rem_re_o,
  output logic [cau_pkg::DEN_W-1:0] rem_im_o,
  output logic [NUM_W-1:0]          nq_re_o,
  output logic [NUM_W-1:0]          nq_im_o
);

  cau_pkg::cau_step_t st_re, st_im;

  // numerator bits shift out at the top, quotient bits shift in at the bottom
  always_comb begin
    st_re = cau_pkg::cau_step(rem_re_i, nq_re_i[NUM_W-1], den_i);
    st_im = cau_pkg::cau_step(rem_im_i, nq_im_i[NUM_W-1], den_i);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_o <= '0;
    end else if (en) begin
      side_o <= side_i;
    end
    if (en) begin
      den_o    <= den_i;
      rem_re_o <= st_re.rem;
      rem_im_o <= st_im.rem;
      nq_re_o  <= {nq_re_i[NUM_W-2:0], st_re.q};
      nq_im_o  <= {nq_im_i[NUM_W-2:0], st_im.q};
    end
  end

endmodule

FILE: src/cau_back.sv
// Back end: sign, saturation, output register and skid buffer.
module cau_back #(
  parameter int NUM_W = cau_pkg::SUM_W + cau_pkg::FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cau_pkg::cau_side_t side_i,
  input  logic [NUM_W-1:0]   q_re_i,
  input  logic [NUM_W-1:0]   q_im_i,
  output logic               skid_v_o,
  output logic               out_valid,
  input  logic               out_stall,
  output cau_pkg::cau_out_t  out_data
);

  localparam int DW = cau_pkg::DATA_WIDTH;
  localparam logic signed [DW-1:0] SAT_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] SAT_MIN = {1'b1, {(DW-1){1'b0}}};

  logic              out_v_r, skid_v_r;
  cau_pkg::cau_out_t out_r, skid_r, res;
  logic signed [NUM_W:0] v_re, v_im;
  logic              ok_re, ok_im, new_v;

  always_comb begin
    if (side_i.is_div) begin
      v_re = side_i.neg_re ? -$signed({1'b0, q_re_i}) : $signed({1'b0, q_re_i});
      v_im = side_i.neg_im ? -$signed({1'b0, q_im_i}) : $signed({1'b0, q_im_i});
    end else begin
      v_re = (NUM_W+1)'(side_i.val_re);
      v_im = (NUM_W+1)'(side_i.val_im);
    end
    ok_re = (&v_re[NUM_W:DW-1]) | ~(|v_re[NUM_W:DW-1]);
    ok_im = (&v_im[NUM_W:DW-1]) | ~(|v_im[NUM_W:DW-1]);
    if (side_i.is_div && side_i.dz) begin
      res.res_re   = '0;
      res.res_im   = '0;
      res.overflow = 1'b0;
      res.div_zero = 1'b1;
    end else begin
      res.res_re   = ok_re ? v_re[DW-1:0] : (v_re[NUM_W] ? SAT_MIN : SAT_MAX);
      res.res_im   = ok_im ? v_im[DW-1:0] : (v_im[NUM_W] ? SAT_MIN : SAT_MAX);
      res.overflow = ~ok_re | ~ok_im;
      res.div_zero = 1'b0;
    end
    new_v = side_i.valid & ~skid_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || !out_stall) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r <= new_v;
      end
    end else if (new_v) begin
      skid_v_r <= 1'b1;
    end
    if (!out_v_r || !out_stall) begin
      out_r <= skid_v_r ? skid_r : res;
    end else if (new_v) begin
      skid_r <= res;
    end
  end

  assign skid_v_o  = skid_v_r;
  assign out_valid = out_v_r;
  assign out_data  = out_r;

`ifndef NO_ASSERTIONS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r) else $error("skid holds data with empty output register");
  a_dz_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_r.div_zero) |-> (!out_r.overflow && out_r.res_re == '0 &&
      out_r.res_im == '0)) else $error("zero divisor result not clean");
  a_ovf_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_r.overflow) |-> (out_r.res_re == SAT_MAX || out_r.res_re == SAT_MIN ||
      out_r.res_im == SAT_MAX || out_r.res_im == SAT_MIN))
    else $error("overflow without saturated part");
  a_skid_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_v_r && out_stall) |=> skid_v_r) else $error("skid entry dropped");
`endif

endmodule

FILE: src/complex_arithmetic_unit.sv
// Complex arithmetic unit top level: front end, divider cell row, back end.
//
// Adds, subtracts, multiplies or divides two complex Q16.16 operands and
// returns one saturated complex result per item. One item is accepted per
// clock cycle while in_stall is low; every item, whatever the operation,
// passes the row of NUM_W restoring divider cells, with NUM_W =
// 2*DATA_WIDTH+1+FRAC_BITS, each of which produces one quotient bit. A
// two-entry output register and skid buffer decouple the sides; in_stall
// rises only when both are occupied.
module complex_arithmetic_unit #(
  parameter int FRAC_BITS = cau_pkg::FRAC_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  cau_pkg::cau_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output cau_pkg::cau_out_t out_data
);

  localparam int NUM_W = cau_pkg::SUM_W + FRAC_BITS;
  localparam int NW    = cau_pkg::DEN_W;

  logic               en, skid_v;
  cau_pkg::cau_side_t side_w [NUM_W+1];
  logic [NW-1:0]      den_w  [NUM_W+1];
  logic [NW-1:0]      rre_w  [NUM_W+1];
  logic [NW-1:0]      rim_w  [NUM_W+1];
  logic [NUM_W-1:0]   nqre_w [NUM_W+1];
  logic [NUM_W-1:0]   nqim_w [NUM_W+1];

  assign en       = ~skid_v;
  assign in_stall = skid_v;
  assign rre_w[0] = '0;
  assign rim_w[0] = '0;

  cau_front #(.FRAC_BITS(FRAC_BITS), .NUM_W(NUM_W)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_valid(in_valid),
    .in_data (in_data),
    .side_o  (side_w[0]),
    .den_o   (den_w[0]),
    .nq_re_o (nqre_w[0]),
    .nq_im_o (nqim_w[0])
  );

  for (genvar i = 0; i < NUM_W; i++) begin : g_cell
    cau_div_cell #(.NUM_W(NUM_W)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .side_i  (side_w[i]),
      .den_i   (den_w[i]),
      .rem_re_i(rre_w[i]),
      .rem_im_i(rim_w[i]),
      .nq_re_i (nqre_w[i]),
      .nq_im_i (nqim_w[i]),
      .side_o  (side_w[i+1]),
      .den_o   (den_w[i+1]),
      .rem_re_o(rre_w[i+1]),
      .rem_im_o(rim_w[i+1]),
      .nq_re_o (nqre_w[i+1]),
      .nq_im_o (nqim_w[i+1])
    );
  end

  cau_back #(.NUM_W(NUM_W)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .side_i   (side_w[NUM_W]),
    .q_re_i   (nqre_w[NUM_W]),
    .q_im_i   (nqim_w[NUM_W]),
    .skid_v_o (skid_v),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // remainders and divisor leaving the last cell are not needed
  logic unused_tail;
  assign unused_tail = ^{rre_w[NUM_W], rim_w[NUM_W], den_w[NUM_W]};

endmodule
